/* design/pidhc_pkg.sv */
// Package for the temperature controller: field widths, register map, reset values,
// the configuration record, sequencer states and the multiplier request/response records.
// No dependencies.
`default_nettype none

package pidhc_pkg;

  localparam int INTEGRAL_LOW_DEF  = -1048576;
  localparam int INTEGRAL_HIGH_DEF = 1048575;
  localparam int OUTPUT_FULL_DEF   = 25600;

  localparam int TEMP_W  = 16;
  localparam int ERR_W   = 17;
  localparam int DIFF_W  = 18;
  localparam int HYST_W  = 15;
  localparam int GAIN_W  = 16;
  localparam int DRV_W   = 15;
  localparam int TERM_W  = 24;
  localparam int INTEG_W = 21;
  localparam int DER_W   = 34;

  localparam int MUL_A_W     = 34;
  localparam int MUL_B_W     = 17;
  localparam int MUL_ACC_W   = 36;
  localparam int MUL_P_W     = 52;
  localparam int MUL_STEPS   = 17;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [HYST_W-1:0] HYST_RST   = 15'd16;
  localparam logic [15:0]       PERIOD_RST = 16'd6554;
  localparam logic [15:0]       INV_RST    = 16'd10;

  typedef enum logic [2:0] {
    REG_CONTROL_MODE   = 3'd0,
    REG_SETPOINT       = 3'd1,
    REG_HYSTERESIS     = 3'd2,
    REG_GAIN_P         = 3'd3,
    REG_GAIN_I         = 3'd4,
    REG_GAIN_D         = 3'd5,
    REG_PERIOD_SECONDS = 3'd6,
    REG_INVERSE_PERIOD = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic              control_mode;
    logic [TEMP_W-1:0] setpoint;
    logic [HYST_W-1:0] hysteresis;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [15:0]       period_seconds;
    logic [15:0]       inverse_period;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_INC,
    ST_MUL_DER,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

/* design/pidhc_serial_mul.sv */
// Bit-serial signed multiplier: one bit of the 17-bit operand per cycle, shift-right accumulate.
// Top operand bit carries negative weight. Depends on pidhc_pkg.
`default_nettype none

module pidhc_serial_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidhc_pkg::mul_req_t req_i,
  output pidhc_pkg::mul_rsp_t rsp_o
);
  import pidhc_pkg::*;

  logic                        run_q;
  logic                        done_q;
  logic [MUL_CNT_W-1:0]        cnt_q;
  logic signed [MUL_ACC_W-1:0] acc_q;
  logic [MUL_B_W-1:0]          low_q;
  logic [MUL_A_W-1:0]          a_q;

  logic                        last;
  logic signed [MUL_ACC_W-1:0] a_ext;
  logic signed [MUL_ACC_W-1:0] addend;
  logic signed [MUL_ACC_W-1:0] sum;

  assign last  = (cnt_q == MUL_CNT_W'(MUL_STEPS - 1));
  assign a_ext = $signed({{(MUL_ACC_W-MUL_A_W){a_q[MUL_A_W-1]}}, a_q});

  always_comb begin
    addend = '0;
    if (low_q[0]) begin
      addend = last ? -a_ext : a_ext;
    end
    sum = acc_q + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      low_q <= req_i.b;
      a_q   <= req_i.a;
    end else if (run_q) begin
      acc_q <= {sum[MUL_ACC_W-1], sum[MUL_ACC_W-1:1]};
      low_q <= {sum[0], low_q[MUL_B_W-1:1]};
    end
  end

  assign rsp_o.busy = run_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = {acc_q[MUL_P_W-MUL_B_W-1:0], low_q};

endmodule

`default_nettype wire

/* design/pidhc_regs.sv */
// APB-style configuration register file for the temperature controller.
// Depends on pidhc_pkg for the register map and the configuration record.
`default_nettype none

module pidhc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pidhc_pkg::ADDR_W-1:0] paddr,
  input  logic [pidhc_pkg::DATA_W-1:0] pwdata,
  output logic [pidhc_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output pidhc_pkg::cfg_t              cfg_o
);
  import pidhc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_mode   <= 1'b0;
      cfg_q.setpoint       <= '0;
      cfg_q.hysteresis     <= HYST_RST;
      cfg_q.gain_p         <= '0;
      cfg_q.gain_i         <= '0;
      cfg_q.gain_d         <= '0;
      cfg_q.period_seconds <= PERIOD_RST;
      cfg_q.inverse_period <= INV_RST;
    end else if (wr) begin
      unique case (idx)
        REG_CONTROL_MODE:   cfg_q.control_mode   <= pwdata[0];
        REG_SETPOINT:       cfg_q.setpoint       <= pwdata[TEMP_W-1:0];
        REG_HYSTERESIS:     cfg_q.hysteresis     <= pwdata[HYST_W-1:0];
        REG_GAIN_P:         cfg_q.gain_p         <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:         cfg_q.gain_i         <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:         cfg_q.gain_d         <= pwdata[GAIN_W-1:0];
        REG_PERIOD_SECONDS: cfg_q.period_seconds <= pwdata[15:0];
        REG_INVERSE_PERIOD: cfg_q.inverse_period <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CONTROL_MODE:   prdata = {{(DATA_W-1){1'b0}}, cfg_q.control_mode};
      REG_SETPOINT:       prdata = {{(DATA_W-TEMP_W){cfg_q.setpoint[TEMP_W-1]}},
                                    cfg_q.setpoint};
      REG_HYSTERESIS:     prdata = {{(DATA_W-HYST_W){1'b0}}, cfg_q.hysteresis};
      REG_GAIN_P:         prdata = {{(DATA_W-GAIN_W){cfg_q.gain_p[GAIN_W-1]}}, cfg_q.gain_p};
      REG_GAIN_I:         prdata = {{(DATA_W-GAIN_W){cfg_q.gain_i[GAIN_W-1]}}, cfg_q.gain_i};
      REG_GAIN_D:         prdata = {{(DATA_W-GAIN_W){cfg_q.gain_d[GAIN_W-1]}}, cfg_q.gain_d};
      REG_PERIOD_SECONDS: prdata = {{(DATA_W-16){1'b0}}, cfg_q.period_seconds};
      REG_INVERSE_PERIOD: prdata = {{(DATA_W-16){1'b0}}, cfg_q.inverse_period};
    endcase
  end

endmodule

`default_nettype wire

/* design/pidhc_seq.sv */
// Sequencer and datapath: error, hysteresis relay, integral clamp, rounding, saturation,
// output sum and the result register. Drives the shared serial multiplier. Depends on pidhc_pkg.
`default_nettype none

module pidhc_seq #(
  parameter int INTEGRAL_LOW  = pidhc_pkg::INTEGRAL_LOW_DEF,
  parameter int INTEGRAL_HIGH = pidhc_pkg::INTEGRAL_HIGH_DEF,
  parameter int OUTPUT_FULL   = pidhc_pkg::OUTPUT_FULL_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pidhc_pkg::cfg_t               cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pidhc_pkg::TEMP_W-1:0]  temperature_i,
  input  logic                          sample_valid_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pidhc_pkg::ERR_W-1:0]   error_value_o,
  output logic                          relay_on_o,
  output logic [pidhc_pkg::DRV_W-1:0]   drive_level_o,
  output logic [pidhc_pkg::TERM_W-1:0]  p_term_o,
  output logic [pidhc_pkg::TERM_W-1:0]  i_term_o,
  output logic [pidhc_pkg::TERM_W-1:0]  d_term_o,
  output logic [pidhc_pkg::INTEG_W-1:0] integral_value_o,
  output pidhc_pkg::mul_req_t           mul_req_o,
  input  pidhc_pkg::mul_rsp_t           mul_rsp_i
);
  import pidhc_pkg::*;

  localparam int ISUM_W = INTEG_W + 1;
  localparam int RND_W  = MUL_P_W - 8;
  localparam int INC_W  = 19;
  localparam int DSUM_W = TERM_W + 2;

  localparam logic signed [ISUM_W-1:0] ILOW  = ISUM_W'(INTEGRAL_LOW);
  localparam logic signed [ISUM_W-1:0] IHIGH = ISUM_W'(INTEGRAL_HIGH);
  localparam logic signed [DSUM_W-1:0] FULL  = DSUM_W'(OUTPUT_FULL);
  localparam logic [DRV_W-1:0]         FULL_DRV = DRV_W'(OUTPUT_FULL);

  function automatic logic [TERM_W-1:0] sat_term(input logic [RND_W-1:0] r);
    logic [TERM_W-1:0] res;
    if (r[RND_W-1:TERM_W-1] == {(RND_W-TERM_W+1){r[TERM_W-1]}}) begin
      res = r[TERM_W-1:0];
    end else begin
      res = r[RND_W-1] ? {1'b1, {(TERM_W-1){1'b0}}} : {1'b0, {(TERM_W-1){1'b1}}};
    end
    return res;
  endfunction

  state_e state_q, state_d;

  logic signed [INTEG_W-1:0] acc_q;
  logic signed [ERR_W-1:0]   last_q;
  logic                      relay_q;

  logic signed [ERR_W-1:0]   e_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic [DER_W-1:0]          deriv_q;
  logic signed [TERM_W-1:0]  p_q, i_q, d_q;
  logic [DRV_W-1:0]          drive_q;
  logic                      relay_res_q;

  logic                      out_valid_q;
  logic [ERR_W-1:0]          out_err_q;
  logic                      out_relay_q;
  logic [DRV_W-1:0]          out_drive_q;
  logic [TERM_W-1:0]         out_p_q, out_i_q, out_d_q;
  logic [INTEG_W-1:0]        out_integ_q;

  logic accept, go_pid, go_onoff, load_out, done;
  logic signed [ERR_W-1:0]  err_in;
  logic signed [DIFF_W-1:0] diff, band_lo, band_hi, t_ext;
  logic                     relay_in;
  logic [MUL_P_W-1:0]       prod;
  logic signed [INC_W-1:0]  inc;
  logic signed [ISUM_W-1:0] isum, integ_next;
  logic [RND_W-1:0]         rnd;
  logic signed [DSUM_W-1:0] dsum;
  logic [DRV_W-1:0]         drive_next;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign go_pid   = accept && sample_valid_i && cfg_i.control_mode;
  assign go_onoff = accept && sample_valid_i && !cfg_i.control_mode;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign done     = mul_rsp_i.done;
  assign prod     = mul_rsp_i.prod;

  assign err_in = $signed({cfg_i.setpoint[TEMP_W-1], cfg_i.setpoint})
                - $signed({temperature_i[TEMP_W-1], temperature_i});
  assign diff   = $signed({e_q[ERR_W-1], e_q}) - $signed({last_q[ERR_W-1], last_q});

  assign t_ext   = $signed({{2{temperature_i[TEMP_W-1]}}, temperature_i});
  assign band_lo = $signed({{2{cfg_i.setpoint[TEMP_W-1]}}, cfg_i.setpoint})
                 - $signed({3'b000, cfg_i.hysteresis});
  assign band_hi = $signed({{2{cfg_i.setpoint[TEMP_W-1]}}, cfg_i.setpoint})
                 + $signed({3'b000, cfg_i.hysteresis});

  always_comb begin
    if (t_ext < band_lo) begin
      relay_in = 1'b1;
    end else if (t_ext > band_hi) begin
      relay_in = 1'b0;
    end else begin
      relay_in = relay_q;
    end
  end

  assign inc  = $signed(prod[16+INC_W-1:16]) + $signed({{(INC_W-1){1'b0}}, prod[15]});
  assign isum = $signed({acc_q[INTEG_W-1], acc_q})
              + $signed({{(ISUM_W-INC_W){inc[INC_W-1]}}, inc});

  always_comb begin
    if (isum < ILOW) begin
      integ_next = ILOW;
    end else if (isum > IHIGH) begin
      integ_next = IHIGH;
    end else begin
      integ_next = isum;
    end
  end

  assign rnd  = prod[MUL_P_W-1:8] + {{(RND_W-1){1'b0}}, prod[7]};
  assign dsum = $signed({{2{p_q[TERM_W-1]}}, p_q}) + $signed({{2{i_q[TERM_W-1]}}, i_q})
              + $signed({{2{d_q[TERM_W-1]}}, d_q});

  always_comb begin
    if (dsum < 0) begin
      drive_next = '0;
    end else if (dsum > FULL) begin
      drive_next = FULL_DRV;
    end else begin
      drive_next = dsum[DRV_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_pid) begin
          state_d = ST_MUL_INC;
        end else if (go_onoff) begin
          state_d = ST_DONE;
        end
      end
      ST_MUL_INC: if (done) state_d = ST_MUL_DER;
      ST_MUL_DER: if (done) state_d = ST_MUL_P;
      ST_MUL_P:   if (done) state_d = ST_MUL_I;
      ST_MUL_I:   if (done) state_d = ST_MUL_D;
      ST_MUL_D:   if (done) state_d = ST_SUM;
      ST_SUM:     state_d = ST_DONE;
      ST_DONE:    if (load_out) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_req_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        mul_req_o.start = go_pid;
        mul_req_o.a     = {{(MUL_A_W-ERR_W){err_in[ERR_W-1]}}, err_in};
        mul_req_o.b     = {1'b0, cfg_i.period_seconds};
      end
      ST_MUL_INC: begin
        mul_req_o.start = done;
        mul_req_o.a     = {{(MUL_A_W-DIFF_W){diff[DIFF_W-1]}}, diff};
        mul_req_o.b     = {1'b0, cfg_i.inverse_period};
      end
      ST_MUL_DER: begin
        mul_req_o.start = done;
        mul_req_o.a     = {{(MUL_A_W-ERR_W){e_q[ERR_W-1]}}, e_q};
        mul_req_o.b     = {cfg_i.gain_p[GAIN_W-1], cfg_i.gain_p};
      end
      ST_MUL_P: begin
        mul_req_o.start = done;
        mul_req_o.a     = {{(MUL_A_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
        mul_req_o.b     = {cfg_i.gain_i[GAIN_W-1], cfg_i.gain_i};
      end
      ST_MUL_I: begin
        mul_req_o.start = done;
        mul_req_o.a     = deriv_q;
        mul_req_o.b     = {cfg_i.gain_d[GAIN_W-1], cfg_i.gain_d};
      end
      default: mul_req_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      last_q      <= '0;
      relay_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        acc_q       <= integ_q;
        last_q      <= e_q;
        relay_q     <= relay_res_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_pid) begin
      e_q         <= err_in;
      relay_res_q <= 1'b0;
    end
    if (go_onoff) begin
      e_q         <= err_in;
      relay_res_q <= relay_in;
      drive_q     <= relay_in ? FULL_DRV : '0;
      p_q         <= '0;
      i_q         <= '0;
      d_q         <= '0;
      integ_q     <= acc_q;
    end
    if (done) begin
      unique case (state_q)
        ST_MUL_INC: integ_q <= integ_next[INTEG_W-1:0];
        ST_MUL_DER: deriv_q <= prod[DER_W-1:0];
        ST_MUL_P:   p_q     <= sat_term(rnd);
        ST_MUL_I:   i_q     <= sat_term(rnd);
        ST_MUL_D:   d_q     <= sat_term(rnd);
        default: ;
      endcase
    end
    if (state_q == ST_SUM) begin
      drive_q <= drive_next;
    end
    if (load_out) begin
      out_err_q   <= e_q;
      out_relay_q <= relay_res_q;
      out_drive_q <= drive_q;
      out_p_q     <= p_q;
      out_i_q     <= i_q;
      out_d_q     <= d_q;
      out_integ_q <= integ_q;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign error_value_o    = out_err_q;
  assign relay_on_o       = out_relay_q;
  assign drive_level_o    = out_drive_q;
  assign p_term_o         = out_p_q;
  assign i_term_o         = out_i_q;
  assign d_term_o         = out_d_q;
  assign integral_value_o = out_integ_q;

endmodule

`default_nettype wire

/* design/pid_or_hysteresis_temp_control.sv */
// Top level of the temperature controller: register file, sequencer and serial multiplier.
// Depends on pidhc_pkg, pidhc_regs, pidhc_seq and pidhc_serial_mul.
//
// One temperature word per control tick. In on/off mode an accepted word goes straight to the
// done state, and its result enters the output register once that register is free; in PID mode
// the word waits on the single bit-serial multiplier (17 steps per product), which forms the five
// products in turn: integral increment, derivative, then the P, I and D terms. A word with
// sample_valid low is taken without leaving idle and gives no result. The next word is accepted once
// the previous result has moved to the output register, even while that result is stalled.
`default_nettype none

module pid_or_hysteresis_temp_control #(
  parameter int INTEGRAL_LOW  = pidhc_pkg::INTEGRAL_LOW_DEF,
  parameter int INTEGRAL_HIGH = pidhc_pkg::INTEGRAL_HIGH_DEF,
  parameter int OUTPUT_FULL   = pidhc_pkg::OUTPUT_FULL_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidhc_pkg::ADDR_W-1:0]  paddr,
  input  logic [pidhc_pkg::DATA_W-1:0]  pwdata,
  output logic [pidhc_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pidhc_pkg::TEMP_W-1:0]  temperature_i,
  input  logic                          sample_valid_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pidhc_pkg::ERR_W-1:0]   error_value_o,
  output logic                          relay_on_o,
  output logic [pidhc_pkg::DRV_W-1:0]   drive_level_o,
  output logic [pidhc_pkg::TERM_W-1:0]  p_term_o,
  output logic [pidhc_pkg::TERM_W-1:0]  i_term_o,
  output logic [pidhc_pkg::TERM_W-1:0]  d_term_o,
  output logic [pidhc_pkg::INTEG_W-1:0] integral_value_o
);
  import pidhc_pkg::*;

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  pidhc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidhc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  pidhc_seq #(
    .INTEGRAL_LOW  (INTEGRAL_LOW),
    .INTEGRAL_HIGH (INTEGRAL_HIGH),
    .OUTPUT_FULL   (OUTPUT_FULL)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .temperature_i    (temperature_i),
    .sample_valid_i   (sample_valid_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .error_value_o    (error_value_o),
    .relay_on_o       (relay_on_o),
    .drive_level_o    (drive_level_o),
    .p_term_o         (p_term_o),
    .i_term_o         (i_term_o),
    .d_term_o         (d_term_o),
    .integral_value_o (integral_value_o),
    .mul_req_o        (mul_req),
    .mul_rsp_i        (mul_rsp)
  );

  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_idle_mul_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !mul_rsp.busy && !mul_rsp.done)
    else $error("multiplier active while sequencer idle");

  a_relay_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && relay_on_o) |->
      (drive_level_o == DRV_W'(OUTPUT_FULL)) && (p_term_o == '0) && (i_term_o == '0)
      && (d_term_o == '0))
    else $error("relay on without full drive and zero terms");

  a_integral_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(integral_value_o) >= INTEGRAL_LOW)
                 && ($signed(integral_value_o) <= INTEGRAL_HIGH))
    else $error("integral outside clamp range");

endmodule

`default_nettype wire
